### sv/rn_pkg.sv
// rn_pkg: shared types and constants for the rational normalizer.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package rn_pkg;

	localparam int DATA_WIDTH = 32;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_GCD,
		ST_EUC,
		ST_DIVN,
		ST_STARTD,
		ST_DIVD,
		ST_WRITE
	} state_t;

	// what the shared divider is working on
	typedef enum logic [1:0] {
		OP_EUCLID,
		OP_NUM,
		OP_DEN
	} div_op_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;       // capture operand magnitudes and sign
		logic    div_start;  // launch a divide
		logic    div_store;  // write back the divider result
		div_op_t div_op;     // which divide is being launched / stored
		logic    out_write;  // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic ab_zero;   // one Euclid operand reached zero
		logic div_done;
		logic out_free;  // output register can take a result
	} sts_t;

endpackage

`default_nettype wire

### sv/rn_if.sv
// rn_in_if / rn_out_if: valid/ready channels of the rational normalizer.
// Depends on rn_pkg for the default data width.
`default_nettype none

interface rn_in_if #(
	parameter int W = rn_pkg::DATA_WIDTH
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] num_in;
	logic signed [W-1:0] den_in;

	modport source (output valid, output num_in, output den_in, input ready);
	modport sink (input valid, input num_in, input den_in, output ready);
endinterface

interface rn_out_if #(
	parameter int W = rn_pkg::DATA_WIDTH
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] num_out;
	logic        [W-2:0] den_out;
	logic                div_zero;

	modport source (output valid, output num_out, output den_out, output div_zero,
		input ready);
	modport sink (input valid, input num_out, input den_out, input div_zero,
		output ready);
endinterface

`default_nettype wire

### sv/rn_divider.sv
// rn_divider: unsigned restoring divider, one quotient bit per cycle.
// Pulses done when quotient and remainder are ready. Depends on rn_pkg.
`default_nettype none

module rn_divider #(
	parameter int W = rn_pkg::DATA_WIDTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] quotient,
	output logic      [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   trial;
	logic [W:0]   diff;
	logic         ge;
	logic [W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[W-1]};
		diff    = trial - {1'b0, dsr_q};
		ge      = (trial >= {1'b0, dsr_q});
		rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

### sv/rn_datapath.sv
// rn_datapath: operand magnitudes, Euclid registers, shared divider and output register.
// Driven by rn_ctrl through rn_pkg::cmd_t; instantiates rn_divider.
`default_nettype none

module rn_datapath #(
	parameter int W = rn_pkg::DATA_WIDTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rn_pkg::cmd_t        cmd,
	output rn_pkg::sts_t             sts,
	input  wire logic signed [W-1:0] num_in,
	input  wire logic signed [W-1:0] den_in,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed      [W-1:0] num_out,
	output logic             [W-2:0] den_out,
	output logic                     div_zero
);
	localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

	logic [W-1:0] nmag_q, dmag_q, a_q, b_q, g_q, rn_q, rd_q;
	logic         neg_q;
	logic         agtb_q;
	logic         out_valid_q;

	logic [W-1:0] nmag, dmag;
	logic [W-1:0] dvd, dvs;
	logic         div_done;
	logic [W-1:0] quo, rem;
	logic [W-1:0] rn_pos, rd_sat;

	assign nmag = num_in[W-1] ? (W'(0) - W'(num_in)) : W'(num_in);
	assign dmag = den_in[W-1] ? (W'(0) - W'(den_in)) : W'(den_in);

	// divider operand select
	always_comb begin
		case (cmd.div_op)
			rn_pkg::OP_EUCLID: begin
				dvd = (a_q > b_q) ? a_q : b_q;
				dvs = (a_q > b_q) ? b_q : a_q;
			end
			rn_pkg::OP_NUM: begin
				dvd = nmag_q;
				dvs = a_q | b_q;   // one side is zero: OR is the gcd
			end
			rn_pkg::OP_DEN: begin
				dvd = dmag_q;
				dvs = g_q;
			end
			default: begin
				dvd = nmag_q;
				dvs = g_q;
			end
		endcase
	end

	rn_divider #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dvd),
		.divisor   (dvs),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nmag_q <= nmag;
			dmag_q <= dmag;
			a_q    <= nmag;
			b_q    <= dmag;
			neg_q  <= num_in[W-1] ^ den_in[W-1];
		end
		if (cmd.div_start) begin
			agtb_q <= (a_q > b_q);
			if (cmd.div_op == rn_pkg::OP_NUM)
				g_q <= a_q | b_q;
		end
		if (cmd.div_store) begin
			case (cmd.div_op)
				rn_pkg::OP_EUCLID: begin
					if (agtb_q)
						a_q <= rem;
					else
						b_q <= rem;
				end
				rn_pkg::OP_NUM: rn_q <= quo;
				rn_pkg::OP_DEN: rd_q <= quo;
				default: ;
			endcase
		end
	end

	// saturation of the reduced magnitudes
	assign rn_pos = rn_q[W-1] ? MAXPOS : rn_q;
	assign rd_sat = rd_q[W-1] ? MAXPOS : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_write)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_write) begin
			if (dmag_q == '0 || nmag_q == '0) begin
				num_out  <= '0;
				den_out  <= (W-1)'(1);
				div_zero <= (dmag_q == '0);
			end else begin
				num_out  <= neg_q ? (W'(0) - rn_q) : rn_pos;
				den_out  <= rd_sat[W-2:0];
				div_zero <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.den_zero = (dmag_q == '0);
		sts.num_zero = (nmag_q == '0);
		sts.ab_zero  = (a_q == '0) || (b_q == '0);
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

### sv/rn_ctrl.sv
// rn_ctrl: sequencer for load, Euclid remainder loop, the two divides and result write.
// Talks to rn_datapath through rn_pkg::cmd_t and rn_pkg::sts_t.
`default_nettype none

module rn_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire rn_pkg::sts_t sts,
	output rn_pkg::cmd_t      cmd
);
	rn_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rn_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.load       = 1'b0;
		cmd.div_start  = 1'b0;
		cmd.div_store  = 1'b0;
		cmd.div_op     = rn_pkg::OP_EUCLID;
		cmd.out_write  = 1'b0;
		case (state_q)
			rn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = rn_pkg::ST_CHECK;
				end
			end
			rn_pkg::ST_CHECK: begin
				if (sts.den_zero || sts.num_zero)
					state_d = rn_pkg::ST_WRITE;
				else
					state_d = rn_pkg::ST_GCD;
			end
			rn_pkg::ST_GCD: begin
				cmd.div_start = 1'b1;
				if (sts.ab_zero) begin
					cmd.div_op = rn_pkg::OP_NUM;
					state_d    = rn_pkg::ST_DIVN;
				end else begin
					state_d = rn_pkg::ST_EUC;
				end
			end
			rn_pkg::ST_EUC: begin
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = rn_pkg::ST_GCD;
				end
			end
			rn_pkg::ST_DIVN: begin
				cmd.div_op = rn_pkg::OP_NUM;
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = rn_pkg::ST_STARTD;
				end
			end
			rn_pkg::ST_STARTD: begin
				cmd.div_op    = rn_pkg::OP_DEN;
				cmd.div_start = 1'b1;
				state_d       = rn_pkg::ST_DIVD;
			end
			rn_pkg::ST_DIVD: begin
				cmd.div_op = rn_pkg::OP_DEN;
				if (sts.div_done) begin
					cmd.div_store = 1'b1;
					state_d       = rn_pkg::ST_WRITE;
				end
			end
			rn_pkg::ST_WRITE: begin
				if (sts.out_free) begin
					cmd.out_write = 1'b1;
					state_d       = rn_pkg::ST_IDLE;
				end
			end
			default: state_d = rn_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### sv/rational_normalizer_core.sv
// rational_normalizer_core: reduces a signed fraction to lowest terms (Euclid gcd).
// Depends on rn_pkg, rn_if, rn_divider, rn_datapath and rn_ctrl.
//
//   channel | dir | payload                          | transaction when
//   --------+-----+----------------------------------+------------------------
//   in_ch   | in  | num_in, den_in (signed)          | in_ch.valid & in_ch.ready
//   out_ch  | out | num_out, den_out, div_zero       | out_ch.valid & out_ch.ready
//
// One transaction is worked on at a time. A zero numerator or denominator
// skips the divides; otherwise the work grows with k, the number of Euclid
// remainder steps, all run on the shared one-bit-per-cycle divider that
// serves both the gcd loop and the two final divides.
// Reset (arst_n low) clears the controller, divider and output valid at once.
// A finished result sits in the output register; a new transaction is taken
// meanwhile, and the controller only stalls when its next result is ready
// while the previous one still has not been taken.
`default_nettype none

module rational_normalizer_core #(
	parameter int DATA_WIDTH = rn_pkg::DATA_WIDTH
) (
	input wire logic   clk,
	input wire logic   arst_n,
	rn_in_if.sink      in_ch,
	rn_out_if.source   out_ch
);
	rn_pkg::cmd_t cmd;
	rn_pkg::sts_t sts;

	// sequencer: owns the input handshake and the order of divides
	rn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: magnitudes, gcd registers, divider, saturation, output register
	rn_datapath #(.W(DATA_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.num_in    (in_ch.num_in),
		.den_in    (in_ch.den_in),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.num_out   (out_ch.num_out),
		.den_out   (out_ch.den_out),
		.div_zero  (out_ch.div_zero)
	);

`ifndef SYNTH
	// only one transaction in flight: input closes right after acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input accepted while a transaction was in flight");

	// a zero denominator always reports 0/1
	a_div_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.div_zero) |->
		(out_ch.num_out == '0 && out_ch.den_out == (DATA_WIDTH-1)'(1)))
		else $error("div_zero result is not 0/1");

	// reduced denominator is never zero
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.den_out != '0))
		else $error("zero denominator on output");
`endif

endmodule

`default_nettype wire
